@@ rtl/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants, codes and types of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int STEP_W      = $clog2(DATA_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_ADD   = "+";
    localparam logic [7:0] CH_SUB   = "-";
    localparam logic [7:0] CH_MUL   = "*";
    localparam logic [7:0] CH_DIV   = "/";
    localparam logic [7:0] CH_MOD   = "%";
    localparam logic [7:0] CH_AND   = "&";
    localparam logic [7:0] CH_OR    = "|";
    localparam logic [7:0] CH_XOR   = "^";
    localparam logic [7:0] CH_SHL   = "<";
    localparam logic [7:0] CH_SHR   = ">";
    localparam logic [7:0] CH_POW   = "#";
    localparam logic [7:0] CH_NOT   = "~";
    localparam logic [7:0] CH_NEG   = "$";

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    typedef enum logic [2:0] {
        STS_OK,
        STS_DIV_ZERO,
        STS_BAD_SHIFT,
        STS_NEG_EXP,
        STS_MISSING,
        STS_BAD_CHAR,
        STS_UNARY_EMPTY,
        STS_OVERFLOW
    } status_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
        OP_XOR, OP_SHL, OP_SHR, OP_POW, OP_NOT, OP_NEG, OP_BAD, OP_END
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              flush;
        logic [DATA_W-1:0] num;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic full;
    } qctl_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_FLUSH, BK_EXEC, BK_OPER, BK_DIV, BK_POW, BK_FIN
    } state_t;

endpackage

@@ rtl/rpn_if.sv @@
// ----------------------------------------------------------------------------
// rpn_in_if / rpn_out_if
// Valid/ready channels for character requests and for results.
// ----------------------------------------------------------------------------
interface rpn_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_code;

    modport source (output valid, output req_type, output char_code, input ready);
    modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface rpn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [2:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

@@ rtl/rpn_ram.sv @@
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rpn_front.sv @@
// ----------------------------------------------------------------------------
// rpn_front
// Accepts characters, builds decimal numbers and classifies operators.
// ----------------------------------------------------------------------------
module rpn_front import rpn_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    rpn_in_if.sink request,
    output qctl_t  qctl,
    input  logic   q_full,
    output cmd_t   q_cmd
);

    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              pend_reg, pend_next;
    logic              accept;
    logic              is_digit;
    logic [3:0]        digit;
    op_t               op;

    assign request.ready = !q_full;
    assign accept   = request.valid && request.ready;
    assign is_digit = (request.req_type == REQ_CHAR) && (request.char_code >= CH_0)
                      && (request.char_code <= CH_9);
    assign digit    = 4'(request.char_code - CH_0);

    always_comb
    begin
        if (request.req_type == REQ_END)
        begin
            op = OP_END;
        end
        else
        begin
            unique case (request.char_code)
                CH_SPACE: op = OP_NOP;
                CH_ADD:   op = OP_ADD;
                CH_SUB:   op = OP_SUB;
                CH_MUL:   op = OP_MUL;
                CH_DIV:   op = OP_DIV;
                CH_MOD:   op = OP_MOD;
                CH_AND:   op = OP_AND;
                CH_OR:    op = OP_OR;
                CH_XOR:   op = OP_XOR;
                CH_SHL:   op = OP_SHL;
                CH_SHR:   op = OP_SHR;
                CH_POW:   op = OP_POW;
                CH_NOT:   op = OP_NOT;
                CH_NEG:   op = OP_NEG;
                default:  op = OP_BAD;
            endcase
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        if (accept)
        begin
            if (is_digit)
            begin
                // acc * 10 as acc * 8 + acc * 2, wrapping at the word width.
                acc_next  = {acc_reg[DATA_W-4:0], 3'b000} + {acc_reg[DATA_W-2:0], 1'b0}
                            + DATA_W'(digit);
                pend_next = 1'b1;
            end
            else
            begin
                acc_next  = '0;
                pend_next = 1'b0;
            end
        end
    end

    assign qctl.push  = accept && !is_digit;
    assign qctl.full  = q_full;
    assign q_cmd.op    = op;
    assign q_cmd.flush = pend_reg;
    assign q_cmd.num   = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
        end
    end

endmodule

@@ rtl/rpn_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// rpn_cmd_queue
// Short command queue between the front and the execution back end.
// ----------------------------------------------------------------------------
module rpn_cmd_queue import rpn_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  qctl_t qctl,
    input  cmd_t  push_cmd,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output cmd_t  pop_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign pop_cmd = slot_reg[rd_reg];
    assign do_push = qctl.push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/rpn_back.sv @@
// ----------------------------------------------------------------------------
// rpn_back
// Executes commands on the operand stack and produces end results.
// ----------------------------------------------------------------------------
module rpn_back import rpn_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  cmd_t         q_cmd,
    output logic         q_pop,
    rpn_out_if.source    result
);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_W-1:0]   top_reg, top_next;
    status_t             err_reg, err_next;
    logic [DATA_W-1:0]   wa_reg, wa_next;
    logic [DATA_W-1:0]   wb_reg, wb_next;
    logic [DATA_W-1:0]   we_reg, we_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                negq_reg, negq_next;
    logic                negr_reg, negr_next;
    logic                ov_reg, ov_next;
    logic [DATA_W-1:0]   oval_reg, oval_next;
    status_t             osts_reg, osts_next;

    logic                ram_we;
    logic [STACK_AW-1:0] ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [STACK_AW-1:0] ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic                is_bin;
    logic                oper_fault;
    logic [DATA_W-1:0]   opa;
    logic [DATA_W-1:0]   opb;
    logic [DATA_W:0]     rem_shift;
    logic [DATA_W:0]     diff;
    logic [DATA_W-1:0]   res;
    logic                push_res;
    logic [CNT_W-1:0]    cnt_m1;
    logic [CNT_W-1:0]    cnt_m2;

    rpn_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign opa    = ram_rdata;
    assign opb    = top_reg;
    assign cnt_m1 = cnt_reg - 1'b1;
    assign cnt_m2 = cnt_reg - 2'd2;
    assign is_bin = !(cmd_reg.op == OP_NOP || cmd_reg.op == OP_NOT || cmd_reg.op == OP_NEG
                      || cmd_reg.op == OP_BAD || cmd_reg.op == OP_END);

    always_comb
    begin
        case (cmd_reg.op)
            OP_DIV, OP_MOD: oper_fault = (opb == '0);
            OP_SHL, OP_SHR: oper_fault = (opb[DATA_W-1:STEP_W] != '0);
            OP_POW:         oper_fault = opb[DATA_W-1];
            default:        oper_fault = 1'b0;
        endcase
    end

    assign q_pop = (state_reg == BK_IDLE) && q_valid;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                state_next = BK_EXEC;
            end
            BK_EXEC:
            begin
                if (cmd_reg.op == OP_END)
                begin
                    if (!ov_reg)
                    begin
                        state_next = BK_IDLE;
                    end
                end
                else if (err_reg == STS_OK && is_bin && cnt_reg >= CNT_W'(2))
                begin
                    state_next = BK_OPER;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_OPER:
            begin
                if (oper_fault)
                begin
                    state_next = BK_IDLE;
                end
                else if (cmd_reg.op == OP_DIV || cmd_reg.op == OP_MOD)
                begin
                    state_next = BK_DIV;
                end
                else if (cmd_reg.op == OP_POW)
                begin
                    state_next = BK_POW;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_DIV, BK_POW:
            begin
                if (step_reg == '0)
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        cmd_next  = cmd_reg;
        cnt_next  = cnt_reg;
        top_next  = top_reg;
        err_next  = err_reg;
        wa_next   = wa_reg;
        wb_next   = wb_reg;
        we_next   = we_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        oval_next = oval_reg;
        osts_next = osts_reg;
        ov_next   = ov_reg && !result.ready;
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[STACK_AW-1:0];
        ram_wdata = top_reg;
        ram_re    = 1'b0;
        ram_raddr = cnt_m2[STACK_AW-1:0];
        rem_shift = {rem_reg, wa_reg[DATA_W-1]};
        diff      = rem_shift - {1'b0, wb_reg};
        res       = '0;
        push_res  = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_cmd;
                end
            end
            BK_FLUSH:
            begin
                if (cmd_reg.flush && err_reg == STS_OK)
                begin
                    if (cnt_reg == CNT_W'(STACK_DEPTH))
                    begin
                        err_next = STS_OVERFLOW;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[STACK_AW-1:0];
                        ram_wdata = cmd_reg.num;
                        top_next  = cmd_reg.num;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
            end
            BK_EXEC:
            begin
                if (cmd_reg.op == OP_END)
                begin
                    if (!ov_reg)
                    begin
                        ov_next = 1'b1;
                        if (err_reg != STS_OK)
                        begin
                            oval_next = '0;
                            osts_next = err_reg;
                        end
                        else if (cnt_reg == '0)
                        begin
                            oval_next = '0;
                            osts_next = STS_MISSING;
                        end
                        else
                        begin
                            oval_next = top_reg;
                            osts_next = STS_OK;
                        end
                        cnt_next = '0;
                        err_next = STS_OK;
                    end
                end
                else if (err_reg == STS_OK)
                begin
                    case (cmd_reg.op)
                        OP_NOP:
                        begin
                        end
                        OP_BAD:
                        begin
                            err_next = STS_BAD_CHAR;
                        end
                        OP_NOT:
                        begin
                            // Complement of an empty stack is silently skipped.
                            if (cnt_reg != '0)
                            begin
                                top_next  = ~top_reg;
                                ram_we    = 1'b1;
                                ram_waddr = cnt_m1[STACK_AW-1:0];
                                ram_wdata = ~top_reg;
                            end
                        end
                        OP_NEG:
                        begin
                            if (cnt_reg == '0)
                            begin
                                err_next = STS_UNARY_EMPTY;
                            end
                            else
                            begin
                                top_next  = '0 - top_reg;
                                ram_we    = 1'b1;
                                ram_waddr = cnt_m1[STACK_AW-1:0];
                                ram_wdata = '0 - top_reg;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg < CNT_W'(2))
                            begin
                                err_next = STS_MISSING;
                            end
                            else
                            begin
                                ram_re = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_OPER:
            begin
                if (oper_fault)
                begin
                    case (cmd_reg.op)
                        OP_DIV, OP_MOD: err_next = STS_DIV_ZERO;
                        OP_SHL, OP_SHR: err_next = STS_BAD_SHIFT;
                        default:        err_next = STS_NEG_EXP;
                    endcase
                end
                else
                begin
                    case (cmd_reg.op)
                        OP_ADD: begin res = opa + opb; push_res = 1'b1; end
                        OP_SUB: begin res = opa - opb; push_res = 1'b1; end
                        OP_MUL: begin res = opa * opb; push_res = 1'b1; end
                        OP_AND: begin res = opa & opb; push_res = 1'b1; end
                        OP_OR:  begin res = opa | opb; push_res = 1'b1; end
                        OP_XOR: begin res = opa ^ opb; push_res = 1'b1; end
                        OP_SHL:
                        begin
                            res      = opa << opb[STEP_W-1:0];
                            push_res = 1'b1;
                        end
                        OP_SHR:
                        begin
                            res      = DATA_W'($signed(opa) >>> opb[STEP_W-1:0]);
                            push_res = 1'b1;
                        end
                        OP_DIV, OP_MOD:
                        begin
                            // Magnitude division; signs are fixed up at the end.
                            wa_next   = opa[DATA_W-1] ? '0 - opa : opa;
                            wb_next   = opb[DATA_W-1] ? '0 - opb : opb;
                            rem_next  = '0;
                            negq_next = opa[DATA_W-1] ^ opb[DATA_W-1];
                            negr_next = opa[DATA_W-1];
                            step_next = STEP_W'(DATA_W - 1);
                        end
                        default:
                        begin
                            wa_next   = DATA_W'(1);
                            wb_next   = opa;
                            we_next   = opb;
                            step_next = STEP_W'(DATA_W - 1);
                        end
                    endcase
                end
            end
            BK_DIV:
            begin
                if (!diff[DATA_W])
                begin
                    rem_next = diff[DATA_W-1:0];
                    wa_next  = {wa_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[DATA_W-1:0];
                    wa_next  = {wa_reg[DATA_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
            end
            BK_POW:
            begin
                if (we_reg[0])
                begin
                    wa_next = wa_reg * wb_reg;
                end
                wb_next   = wb_reg * wb_reg;
                we_next   = we_reg >> 1;
                step_next = step_reg - 1'b1;
            end
            BK_FIN:
            begin
                case (cmd_reg.op)
                    OP_DIV:  res = negq_reg ? '0 - wa_reg : wa_reg;
                    OP_MOD:  res = negr_reg ? '0 - rem_reg : rem_reg;
                    default: res = wa_reg;
                endcase
                push_res = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Two operands pop and one result takes the lower slot.
        if (push_res)
        begin
            top_next  = res;
            cnt_next  = cnt_m1;
            ram_we    = 1'b1;
            ram_waddr = cnt_m2[STACK_AW-1:0];
            ram_wdata = res;
        end
    end

    assign result.valid  = ov_reg;
    assign result.value  = oval_reg;
    assign result.status = osts_reg;

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        top_reg  <= top_next;
        wa_reg   <= wa_next;
        wb_reg   <= wb_next;
        we_reg   <= we_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        oval_reg <= oval_next;
        osts_reg <= osts_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
            err_reg   <= STS_OK;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

@@ rtl/postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Integer evaluator for postfix expressions fed one character per request.
// ----------------------------------------------------------------------------
// The request channel carries one ASCII character per request, or an end
// request that asks for the result. The result channel carries one value and
// status for each end request and nothing else.
// Digits are folded into a number in the front and never
// enter the queue, but like every request they wait while the queue is full.
// Any other character becomes a command in a two-entry queue, which
// the back end executes against a 64-entry stack RAM; division,
// remainder and power run the one-bit-per-cycle divider and the
// square-and-multiply loop of 32 steps.
// The front keeps accepting requests while the queue has room, so a slow
// operator only stalls the request channel once the queue is full.
// An end request's result waits in an output register until taken,
// and further end requests wait behind it.
// Reset clears the stack count, number accumulator and latched status at
// once; the stack RAM itself needs no clearing.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator import rpn_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    rpn_in_if.sink     request,
    rpn_out_if.source  result
);

    qctl_t qctl;
    cmd_t  front_cmd;
    cmd_t  back_cmd;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    rpn_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .qctl    (qctl),
        .q_full  (q_full),
        .q_cmd   (front_cmd)
    );

    rpn_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .qctl     (qctl),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (back_cmd)
    );

    rpn_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (back_cmd),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

@@ rtl/rpn_checker.sv @@
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks of the evaluator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rpn_checker import rpn_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_req_type,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value,
    input logic [2:0]  out_status
);

    logic [2:0] open_reg, open_next;
    logic       end_in;
    logic       res_out;

    assign end_in  = in_valid && in_ready && (in_req_type == REQ_END);
    assign res_out = out_valid && out_ready;

    always_comb
    begin
        open_next = open_reg + 3'(end_in) - 3'(res_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    // A failed expression always reports a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != STS_OK |-> out_value == 32'd0)
        else $error("result with error status carries a nonzero value");

    // Every result answers an end request that is still outstanding.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_reg != 3'd0)
        else $error("result without an outstanding end request");

    // Queue, back end and output register bound the outstanding end requests.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= 3'd4)
        else $error("too many end requests outstanding");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
        else $error("stalled result changed");

endmodule

bind postfix_expression_evaluator rpn_checker u_rpn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (request.valid),
    .in_ready    (request.ready),
    .in_req_type (request.req_type),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_value   (result.value),
    .out_status  (result.status)
);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives postfix expressions into the evaluator one character per request;
// a directed table of typed expectations covers each operator and error
// case; random expressions, checked against a cycle-free stack predictor,
// follow under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rpn_pkg::*;

    typedef struct {
        string       text;
        logic [31:0] value;
        status_t     status;
    } expr_row_t;

    logic clk;
    logic rst_n;
    rpn_in_if  request ();
    rpn_out_if result ();

    postfix_expression_evaluator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result)
    );

    // Predictor state.
    logic [31:0] stack_mem [STACK_DEPTH];
    int          stack_cnt;
    logic [31:0] num_acc;
    logic        num_pending;
    status_t     err_sts;

    logic [31:0] want_value [$];
    status_t     want_status [$];

    int  errors;
    int  results_seen;
    int  ends_sent;
    int  chars_sent;
    int  idle_pct;
    int  stall_pct;
    longint cycle_cnt;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void latch_error(input status_t code);
        if (err_sts == STS_OK)
            err_sts = code;
    endfunction

    function automatic void push_operand(input logic [31:0] v);
        if (stack_cnt >= STACK_DEPTH)
            latch_error(STS_OVERFLOW);
        else
        begin
            stack_mem[stack_cnt] = v;
            stack_cnt++;
        end
    endfunction

    function automatic void flush_number();
        if (num_pending)
        begin
            push_operand(num_acc);
            num_pending = 1'b0;
            num_acc = '0;
        end
    endfunction

    function automatic void apply_binary(input logic [7:0] ch);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [31:0] base;
        logic [31:0] ex;
        longint      sa;
        longint      sb;
        longint      q;
        if (stack_cnt < 2)
        begin
            latch_error(STS_MISSING);
            return;
        end
        b = stack_mem[stack_cnt-1];
        a = stack_mem[stack_cnt-2];
        stack_cnt -= 2;
        sa = longint'($signed(a));
        sb = longint'($signed(b));
        r = '0;
        case (ch)
            CH_ADD: r = a + b;
            CH_SUB: r = a - b;
            CH_MUL: r = a * b;
            CH_AND: r = a & b;
            CH_OR:  r = a | b;
            CH_XOR: r = a ^ b;
            CH_DIV, CH_MOD:
            begin
                if (b == 0)
                begin
                    latch_error(STS_DIV_ZERO);
                    return;
                end
                q = (ch == CH_DIV) ? sa / sb : sa % sb;
                r = q[31:0];
            end
            CH_SHL, CH_SHR:
            begin
                if (sb < 0 || sb > 31)
                begin
                    latch_error(STS_BAD_SHIFT);
                    return;
                end
                r = (ch == CH_SHL) ? a << b[4:0] : $unsigned($signed(a) >>> b[4:0]);
            end
            default:
            begin
                if (sb < 0)
                begin
                    latch_error(STS_NEG_EXP);
                    return;
                end
                r = 32'd1;
                base = a;
                ex = b;
                while (ex != 0)
                begin
                    if (ex[0])
                        r = r * base;
                    base = base * base;
                    ex = ex >> 1;
                end
            end
        endcase
        push_operand(r);
    endfunction

    // Advances the predictor by one request; an end request queues a result.
    function automatic void predict_request(input logic req, input logic [7:0] ch);
        logic [31:0] v;
        status_t     s;
        if (req == REQ_END)
        begin
            if (err_sts == STS_OK)
                flush_number();
            v = '0;
            if (err_sts != STS_OK)
                s = err_sts;
            else if (stack_cnt == 0)
                s = STS_MISSING;
            else
            begin
                v = stack_mem[stack_cnt-1];
                s = STS_OK;
            end
            want_value.push_back(v);
            want_status.push_back(s);
            stack_cnt = 0;
            num_acc = '0;
            num_pending = 1'b0;
            err_sts = STS_OK;
            return;
        end
        if (err_sts != STS_OK)
            return;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            num_acc = num_acc * 10 + 32'(ch - CH_0);
            num_pending = 1'b1;
            return;
        end
        flush_number();
        if (err_sts != STS_OK)
            return;
        case (ch)
            CH_SPACE: ;
            CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD, CH_AND, CH_OR, CH_XOR,
            CH_SHL, CH_SHR, CH_POW:
                apply_binary(ch);
            CH_NOT:
                if (stack_cnt != 0)
                    stack_mem[stack_cnt-1] = ~stack_mem[stack_cnt-1];
            CH_NEG:
                if (stack_cnt != 0)
                    stack_mem[stack_cnt-1] = -stack_mem[stack_cnt-1];
                else
                    latch_error(STS_UNARY_EMPTY);
            default:
                latch_error(STS_BAD_CHAR);
        endcase
    endfunction

    // Presents one request and holds it until the block takes it.
    task automatic send_request(input logic req, input logic [7:0] ch);
        while ($urandom_range(99) < idle_pct)
        begin
            request.valid <= 1'b0;
            @(posedge clk);
        end
        request.valid     <= 1'b1;
        request.req_type  <= req;
        request.char_code <= ch;
        do
            @(posedge clk);
        while (!request.ready);
        predict_request(req, ch);
        if (req == REQ_END)
            ends_sent++;
        else
            chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_request(REQ_CHAR, s[i]);
    endtask

    task automatic drain_results();
        request.valid <= 1'b0;
        while (want_value.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Random decimal operand: mostly short, sometimes near the full range.
    function automatic string random_number();
        case ($urandom_range(3))
            0: return $sformatf("%0d", $urandom_range(9));
            1: return $sformatf("%0d", $urandom_range(40));
            2: return $sformatf("%0d", $urandom_range(100000));
            default: return $sformatf("%0d", $urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_operator();
        logic [7:0] ops [13] = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD, CH_AND,
                                 CH_OR, CH_XOR, CH_SHL, CH_SHR, CH_POW, CH_NOT,
                                 CH_NEG};
        return ops[$urandom_range(12)];
    endfunction

    // Mostly well-formed postfix with random content, plus noise and
    // the odd run deep enough to fill the stack.
    task automatic send_random_expression();
        int depth;
        int steps;
        depth = 0;
        steps = $urandom_range(1, 8);
        if ($urandom_range(49) == 0)
            steps = $urandom_range(60, 70);
        for (int k = 0; k < steps; k++)
        begin
            if (depth < 2 || $urandom_range(2) == 0 || steps > 20)
            begin
                send_text(random_number());
                depth++;
            end
            else
            begin
                send_request(REQ_CHAR, random_operator());
                depth--;
            end
            if ($urandom_range(2) != 0)
                send_request(REQ_CHAR, CH_SPACE);
            if ($urandom_range(29) == 0)
                send_request(REQ_CHAR, 8'($urandom_range(255)));
        end
        while (depth > 1 && $urandom_range(3) != 0)
        begin
            send_request(REQ_CHAR, random_operator());
            depth--;
        end
        send_request(REQ_END, 8'($urandom_range(255)));
    endtask

    always @(posedge clk)
    begin
        if (result.valid && result.ready)
        begin
            if (want_value.size() == 0)
            begin
                report_mismatch("unexpected result", result.value, 32'd0);
            end
            else
            begin
                if (result.value !== want_value[0])
                    report_mismatch("value", result.value, want_value[0]);
                if (result.status !== want_status[0])
                    report_mismatch("status", 32'(result.status), 32'(want_status[0]));
                void'(want_value.pop_front());
                void'(want_status.pop_front());
                results_seen++;
            end
        end
        result.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > 2000000)
        begin
            $display("[postfix_expression_evaluator] ERROR");
            $finish;
        end
    end

    initial
    begin
        expr_row_t   rows [$];
        string       deep;
        int          phase_idle [4] = '{0, 88, 0, 15};
        int          phase_stall [4] = '{0, 0, 88, 15};
        errors = 0;
        results_seen = 0;
        ends_sent = 0;
        chars_sent = 0;
        cycle_cnt = 0;
        idle_pct = 0;
        stall_pct = 0;
        stack_cnt = 0;
        num_acc = '0;
        num_pending = 1'b0;
        err_sts = STS_OK;
        rst_n = 1'b0;
        request.valid = 1'b0;
        request.req_type = REQ_CHAR;
        request.char_code = '0;
        result.ready = 1'b0;

        rows.push_back('{"", 32'd0, STS_MISSING});
        rows.push_back('{"4294967295", 32'hFFFF_FFFF, STS_OK});
        rows.push_back('{"3 4+", 32'd7, STS_OK});
        rows.push_back('{"3 4-", 32'hFFFF_FFFF, STS_OK});
        rows.push_back('{"6 7*", 32'd42, STS_OK});
        rows.push_back('{"7 2/", 32'd3, STS_OK});
        rows.push_back('{"7 0/", 32'd0, STS_DIV_ZERO});
        rows.push_back('{"7 3%", 32'd1, STS_OK});
        rows.push_back('{"12 10&", 32'd8, STS_OK});
        rows.push_back('{"12 10|", 32'd14, STS_OK});
        rows.push_back('{"12 10^", 32'd6, STS_OK});
        rows.push_back('{"1 31<", 32'h8000_0000, STS_OK});
        rows.push_back('{"1 32<", 32'd0, STS_BAD_SHIFT});
        rows.push_back('{"1$ 1>", 32'hFFFF_FFFF, STS_OK});
        rows.push_back('{"2 10#", 32'd1024, STS_OK});
        rows.push_back('{"0 0#", 32'd1, STS_OK});
        rows.push_back('{"2 1$#", 32'd0, STS_NEG_EXP});
        rows.push_back('{"5+", 32'd0, STS_MISSING});
        rows.push_back('{"~", 32'd0, STS_MISSING});
        rows.push_back('{"5~", 32'hFFFF_FFFA, STS_OK});
        rows.push_back('{"$", 32'd0, STS_UNARY_EMPTY});
        rows.push_back('{"a", 32'd0, STS_BAD_CHAR});
        rows.push_back('{"2147483648 1$/", 32'h8000_0000, STS_OK});
        rows.push_back('{"2147483648 1$%", 32'd0, STS_OK});
        rows.push_back('{"a 1 0/", 32'd0, STS_BAD_CHAR});
        // A full stack, then a pending number pushed by the end request.
        deep = "";
        for (int i = 0; i < STACK_DEPTH; i++)
            deep = {deep, "1 "};
        rows.push_back('{{deep, "9"}, 32'd0, STS_OVERFLOW});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
        begin
            send_text(rows[r].text);
            send_request(REQ_END, 8'hFF);
            // The typed expectation stands in for the predicted one.
            want_value[$] = rows[r].value;
            want_status[$] = rows[r].status;
        end
        send_request(REQ_CHAR, 8'h00);
        send_request(REQ_END, 8'h00);
        want_value[$] = 32'd0;
        want_status[$] = STS_BAD_CHAR;
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            while (chars_sent + ends_sent < 280 + 210 * p)
                send_random_expression();
            drain_results();
        end

        $display("%0d character and %0d end requests sent, %0d results checked",
                 chars_sent, ends_sent, results_seen);
        if (errors == 0 && want_value.size() == 0)
            $display("[postfix_expression_evaluator] OK");
        else
            $display("[postfix_expression_evaluator] ERROR");
        $finish;
    end
endmodule
